### src/swqd_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window quiet detector package
// Shared constants, register indexes, state types and the control and status
// structs that pass between the sequencer and the monotonic queues.
// ----------------------------------------------------------------------------
package swqd_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int LEN_W       = 11;
   localparam int THRESH_W    = 16;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_LENGTH   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUIET_THRESHOLD = 1'b1;

   localparam logic KIND_QUIET = 1'b0;
   localparam logic KIND_NONE  = 1'b1;

   localparam logic [LEN_W-1:0]    WINDOW_LENGTH_RESET   = LEN_W'(1);
   localparam logic [THRESH_W-1:0] QUIET_THRESHOLD_RESET = '0;

   typedef enum logic [1:0] {
      TS_IDLE,
      TS_QUEUE,
      TS_EVAL
   } top_state_type;

   typedef enum logic [2:0] {
      QS_IDLE,
      QS_EXPIRE,
      QS_EXPIRE_LOAD,
      QS_TRIM,
      QS_TRIM_LOAD,
      QS_PUSH
   } queue_state_type;

   typedef struct packed {
      logic start;
      logic flush;
      logic keep_max;
   } queue_ctrl_type;

   typedef struct packed {
      logic                       busy;
      logic signed [SAMPLE_W-1:0] front_sample;
   } queue_stat_type;

endpackage

### src/swqd_channels.sv
// ----------------------------------------------------------------------------
// Sliding window quiet detector channels
// Valid/ready interfaces for the sample stream and the result stream.
// ----------------------------------------------------------------------------
interface swqd_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample;
   logic               last_sample;

   modport source (output valid, output sample, output last_sample, input ready);
   modport sink (input valid, input sample, input last_sample, output ready);
endinterface

interface swqd_rsp_if #(parameter int POSITION_BITS = 24);
   logic                     valid;
   logic                     ready;
   logic                     result_kind;
   logic [POSITION_BITS-1:0] start_position;

   modport source (output valid, output result_kind, output start_position, input ready);
   modport sink (input valid, input result_kind, input start_position, output ready);
endinterface

### src/swqd_mono_queue.sv
// ----------------------------------------------------------------------------
// Sliding window quiet detector monotonic queue
// One circular queue of (ring index, sample) entries kept monotonic by a
// single comparator; expires old entries at the front, trims the back and
// pushes the new sample, one memory access per step.
// ----------------------------------------------------------------------------
module swqd_mono_queue
   import swqd_pkg::*;
#(
   parameter int WINDOW_MAX = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  queue_ctrl_type                        ctrl,
   input  logic [$clog2(WINDOW_MAX)-1:0]         now_idx,
   input  logic [$clog2(WINDOW_MAX+1)-1:0]       win_len,
   input  logic signed [SAMPLE_W-1:0]            sample,
   output queue_stat_type                        stat
);

   localparam int IDX_W   = $clog2(WINDOW_MAX);
   localparam int CNT_W   = $clog2(WINDOW_MAX+1);
   localparam int ENTRY_W = IDX_W + SAMPLE_W;

   logic [ENTRY_W-1:0] mem [WINDOW_MAX];
   logic [ENTRY_W-1:0] rd_data_ff;

   queue_state_type    state_ff, state_in;
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [ENTRY_W-1:0] front_ff, front_in;
   logic [ENTRY_W-1:0] back_ff, back_in;

   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] wr_data;

   logic [IDX_W-1:0]           front_idx;
   logic signed [SAMPLE_W-1:0] back_val;
   logic [CNT_W-1:0]           age_raw;
   logic [CNT_W-1:0]           age;
   logic [IDX_W-1:0]           head_next;
   logic                       expire_hit;
   logic                       trim_hit;

   function automatic logic [IDX_W-1:0] wrap_idx(input logic [CNT_W:0] s);
      logic [CNT_W:0] t;
      t = s;
      if (s >= (CNT_W+1)'(WINDOW_MAX)) begin
         t = s - (CNT_W+1)'(WINDOW_MAX);
      end
      return t[IDX_W-1:0];
   endfunction

   assign front_idx = front_ff[ENTRY_W-1 -: IDX_W];
   assign back_val  = signed'(back_ff[SAMPLE_W-1:0]);
   assign head_next = (head_ff == IDX_W'(WINDOW_MAX-1)) ? '0 : head_ff + IDX_W'(1);

   // Ring indexes wrap, so age is taken modulo the ring size. An entry is never
   // as young as the current sample here, so a zero difference means a full lap.
   always_comb begin
      if (now_idx >= front_idx) begin
         age_raw = CNT_W'(now_idx) - CNT_W'(front_idx);
      end else begin
         age_raw = CNT_W'(now_idx) + CNT_W'(WINDOW_MAX) - CNT_W'(front_idx);
      end
      age = (age_raw == '0) ? CNT_W'(WINDOW_MAX) : age_raw;
   end

   assign expire_hit = (count_ff != '0) && (age >= win_len);
   assign trim_hit   = (count_ff != '0) &&
                       (ctrl.keep_max ? (back_val <= sample) : (back_val >= sample));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         QS_IDLE: begin
            if (ctrl.start) state_in = QS_EXPIRE;
         end
         QS_EXPIRE: begin
            state_in = expire_hit ? QS_EXPIRE_LOAD : QS_TRIM;
         end
         QS_EXPIRE_LOAD: state_in = QS_EXPIRE;
         QS_TRIM: begin
            state_in = trim_hit ? QS_TRIM_LOAD : QS_PUSH;
         end
         QS_TRIM_LOAD: state_in = QS_TRIM;
         QS_PUSH: state_in = QS_IDLE;
         default: state_in = QS_IDLE;
      endcase
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      front_in = front_ff;
      back_in  = back_ff;
      rd_addr  = head_next;
      wr_en    = 1'b0;
      wr_addr  = wrap_idx((CNT_W+1)'(head_ff) + (CNT_W+1)'(count_ff));
      wr_data  = {now_idx, sample};
      unique case (state_ff)
         QS_EXPIRE: begin
            if (expire_hit) begin
               head_in  = head_next;
               count_in = count_ff - CNT_W'(1);
            end
         end
         QS_EXPIRE_LOAD: front_in = rd_data_ff;
         QS_TRIM: begin
            if (trim_hit) begin
               count_in = count_ff - CNT_W'(1);
               // Fetch the entry that becomes the new back.
               rd_addr  = wrap_idx((CNT_W+1)'(head_ff) + (CNT_W+1)'(count_ff)
                                   - (CNT_W+1)'(2));
            end
         end
         QS_TRIM_LOAD: back_in = rd_data_ff;
         QS_PUSH: begin
            wr_en    = 1'b1;
            count_in = count_ff + CNT_W'(1);
            back_in  = wr_data;
            if (count_ff == '0) front_in = wr_data;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.flush) begin
         state_ff <= QS_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
      front_ff <= front_in;
      back_ff  <= back_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   assign stat.busy         = (state_ff != QS_IDLE);
   assign stat.front_sample = signed'(front_ff[SAMPLE_W-1:0]);

endmodule

### src/sliding_window_quiet_detector.sv
// ----------------------------------------------------------------------------
// Sliding window quiet detector
// Tracks max and min over the last window_length samples and reports the
// start position of every window whose spread stays within the threshold.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one signed sample per transaction, with last_sample set
//   on the final sample of a stream. rsp_chan returns at most one result per
//   sample: kind 0 with the 1-based start position of a quiet window, or kind
//   1 with position 0 when a stream ends without any quiet window. Registers
//   are written through csr_write/csr_index/csr_wdata, by the user only while
//   the block is idle; the block itself does not enforce this. A sample is
//   accepted, then both monotonic queues expire old entries at the front, trim
//   the back and push it, with one memory read for each entry removed; once
//   both queues are done the sample is evaluated and any result registered.
//   The next sample is taken once the block is back in idle. Each sample
//   enters and leaves each queue once. The block takes no sample while one is in
//   work. A finished result sits in the output register while the next
//   sample is processed; if it is still not taken when the next result is
//   ready, the block holds until it is.
//   Reset empties both queues, clears the stream counters and drops any
//   pending result; registers return to length 1 and threshold 0. The last
//   sample of a stream clears the stream state in the same way.
// ----------------------------------------------------------------------------
module sliding_window_quiet_detector
   import swqd_pkg::*;
#(
   parameter int WINDOW_MAX    = 1024,
   parameter int POSITION_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   swqd_req_if.sink               req_chan,
   swqd_rsp_if.source             rsp_chan,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int IDX_W  = $clog2(WINDOW_MAX);
   localparam int AGE_W  = $clog2(WINDOW_MAX+1);
   localparam int LCMP_W = (AGE_W > LEN_W) ? AGE_W : LEN_W;
   localparam int POS_W  = ((POSITION_BITS > AGE_W) ? POSITION_BITS : AGE_W) + 1;

   top_state_type              state_ff, state_in;
   logic [LEN_W-1:0]           win_len_ff, win_len_in;
   logic [THRESH_W-1:0]        thresh_ff, thresh_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic                       last_ff, last_in;
   logic [IDX_W-1:0]           now_idx_ff, now_idx_in;
   logic [POSITION_BITS-1:0]   seen_ff, seen_in;
   logic                       found_ff, found_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       kind_ff, kind_in;
   logic [POSITION_BITS-1:0]   pos_ff, pos_in;

   queue_ctrl_type max_ctrl, min_ctrl;
   queue_stat_type max_stat, min_stat;

   logic                 accept;
   logic [LCMP_W-1:0]    len_raw;
   logic [AGE_W-1:0]     eff_len;
   logic                 window_full;
   logic [POS_W-1:0]     pos_wide;
   logic signed [SAMPLE_W:0] span;
   logic                 quiet;
   logic                 none_found;
   logic                 has_result;
   logic                 out_free;
   logic                 eval_done;

   assign req_chan.ready = (state_ff == TS_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;

   // Length zero counts as one; lengths past the ring size are clamped.
   always_comb begin
      len_raw = LCMP_W'(win_len_ff);
      if (len_raw == '0) begin
         eff_len = AGE_W'(1);
      end else if (len_raw > LCMP_W'(WINDOW_MAX)) begin
         eff_len = AGE_W'(WINDOW_MAX);
      end else begin
         eff_len = len_raw[AGE_W-1:0];
      end
   end

   assign window_full = POS_W'(seen_ff) >= POS_W'(eff_len);
   assign pos_wide    = POS_W'(seen_ff) - POS_W'(eff_len) + POS_W'(1);
   assign span        = {max_stat.front_sample[SAMPLE_W-1], max_stat.front_sample}
                      - {min_stat.front_sample[SAMPLE_W-1], min_stat.front_sample};
   assign quiet       = window_full && !span[SAMPLE_W] &&
                        (span[SAMPLE_W-1:0] <= thresh_ff);
   assign none_found  = last_ff && !found_ff && !quiet;
   assign has_result  = quiet || none_found;
   assign out_free    = !rsp_valid_ff || rsp_chan.ready;
   assign eval_done   = (state_ff == TS_EVAL) && (!has_result || out_free);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         TS_IDLE: begin
            if (accept) state_in = TS_QUEUE;
         end
         TS_QUEUE: begin
            if (!max_stat.busy && !min_stat.busy) state_in = TS_EVAL;
         end
         TS_EVAL: begin
            if (eval_done) state_in = TS_IDLE;
         end
         default: state_in = TS_IDLE;
      endcase
   end

   always_comb begin
      win_len_in   = win_len_ff;
      thresh_in    = thresh_ff;
      sample_in    = sample_ff;
      last_in      = last_ff;
      now_idx_in   = now_idx_ff;
      seen_in      = seen_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff;
      kind_in      = kind_ff;
      pos_in       = pos_ff;

      max_ctrl.start    = accept;
      max_ctrl.flush    = 1'b0;
      max_ctrl.keep_max = 1'b1;
      min_ctrl.start    = accept;
      min_ctrl.flush    = 1'b0;
      min_ctrl.keep_max = 1'b0;

      if (csr_write) begin
         unique case (csr_index)
            CSR_WINDOW_LENGTH:   win_len_in = csr_wdata[LEN_W-1:0];
            CSR_QUIET_THRESHOLD: thresh_in  = csr_wdata[THRESH_W-1:0];
            default: ;
         endcase
      end

      if (accept) begin
         sample_in = req_chan.sample;
         last_in   = req_chan.last_sample;
         if (seen_ff != '1) seen_in = seen_ff + POSITION_BITS'(1);
      end

      if (rsp_valid_ff && rsp_chan.ready) rsp_valid_in = 1'b0;

      if (eval_done) begin
         if (has_result) begin
            rsp_valid_in = 1'b1;
            kind_in      = quiet ? KIND_QUIET : KIND_NONE;
            pos_in       = quiet ? pos_wide[POSITION_BITS-1:0] : '0;
         end
         if (quiet) found_in = 1'b1;
         if (last_ff) begin
            now_idx_in     = '0;
            seen_in        = '0;
            found_in       = 1'b0;
            max_ctrl.flush = 1'b1;
            min_ctrl.flush = 1'b1;
         end else begin
            now_idx_in = (now_idx_ff == IDX_W'(WINDOW_MAX-1)) ? '0
                                                               : now_idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= TS_IDLE;
         win_len_ff   <= WINDOW_LENGTH_RESET;
         thresh_ff    <= QUIET_THRESHOLD_RESET;
         now_idx_ff   <= '0;
         seen_ff      <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         win_len_ff   <= win_len_in;
         thresh_ff    <= thresh_in;
         now_idx_ff   <= now_idx_in;
         seen_ff      <= seen_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff <= sample_in;
      last_ff   <= last_in;
      kind_ff   <= kind_in;
      pos_ff    <= pos_in;
   end

   swqd_mono_queue #(.WINDOW_MAX(WINDOW_MAX)) u_max_queue (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (max_ctrl),
      .now_idx (now_idx_ff),
      .win_len (eff_len),
      .sample  (sample_ff),
      .stat    (max_stat)
   );

   swqd_mono_queue #(.WINDOW_MAX(WINDOW_MAX)) u_min_queue (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (min_ctrl),
      .now_idx (now_idx_ff),
      .win_len (eff_len),
      .sample  (sample_ff),
      .stat    (min_stat)
   );

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.result_kind    = kind_ff;
   assign rsp_chan.start_position = pos_ff;

   // The queues only work while the sequencer waits on them.
   assert property (@(posedge clock) disable iff (reset)
      (max_stat.busy || min_stat.busy) |-> (state_ff == TS_QUEUE))
      else $error("queue busy outside the queue phase");

   // A quiet window always starts at a position of one or more.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && kind_ff == KIND_QUIET) |-> (pos_ff != '0))
      else $error("quiet result with zero start position");

   // A none-found result carries no position.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && kind_ff == KIND_NONE) |-> (pos_ff == '0))
      else $error("none-found result with a position");

   // Finishing the last sample leaves a fresh stream behind.
   assert property (@(posedge clock) disable iff (reset)
      (eval_done && last_ff) |=> (seen_ff == '0 && !found_ff && now_idx_ff == '0))
      else $error("stream state not cleared after last sample");

   // A new result never overwrites one still waiting.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready && state_ff == TS_EVAL && has_result)
         |=> (state_ff == TS_EVAL))
      else $error("result register overrun");

endmodule
